@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Assert a property on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Assert a property on clk_i / rst_ni of the enclosing module.
`define ASSERT_DEF(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_DEF(lbl, prop, msg)
`endif
`endif

@@ sv/csl_pkg.sv @@
// ----------------------------------------------------------------------------
// csl_pkg
// Types, codes and the keyword table of the C subset lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package csl_pkg;

  localparam int unsigned MAX_TOKEN_LEN_DEF = 255;
  localparam int unsigned OFFSET_BITS_DEF   = 16;
  localparam int unsigned PREFIX_LEN        = 6;
  localparam int unsigned PREFIX_IDX_W      = $clog2(PREFIX_LEN);
  localparam int unsigned QUEUE_DEPTH       = 4;
  localparam int unsigned QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);

  // Token kinds
  localparam logic [2:0] KIND_IDENT   = 3'd0;
  localparam logic [2:0] KIND_KEYWORD = 3'd1;
  localparam logic [2:0] KIND_SEP     = 3'd2;
  localparam logic [2:0] KIND_LITERAL = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;

  // Keyword indexes
  localparam logic [2:0] KW_INT    = 3'd0;
  localparam logic [2:0] KW_FLOAT  = 3'd1;
  localparam logic [2:0] KW_IF     = 3'd2;
  localparam logic [2:0] KW_ELSE   = 3'd3;
  localparam logic [2:0] KW_WHILE  = 3'd4;
  localparam logic [2:0] KW_RETURN = 3'd5;
  localparam logic [2:0] KW_VOID   = 3'd6;
  localparam logic [2:0] KW_NONE   = 3'd7;

  typedef logic [PREFIX_LEN-1:0][7:0] prefix_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } csl_in_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [2:0]  keyword_index;
    logic [7:0]  first_char;
    logic [15:0] token_start;
    logic [7:0]  token_length;
    logic [15:0] token_line;
    logic        too_long;
    logic        last;
  } csl_out_t;

  // Tokens produced by one accepted item, oldest in tok0.
  typedef struct packed {
    logic [1:0] push_n;
    csl_out_t   tok0;
    csl_out_t   tok1;
  } csl_push_t;

  typedef struct packed {
    logic [QUEUE_PTR_W:0] level;
    logic                 room_two;
  } csl_queue_stat_t;

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] n;
    case (k)
      KW_INT:    n = 3'd3;
      KW_FLOAT:  n = 3'd5;
      KW_IF:     n = 3'd2;
      KW_ELSE:   n = 3'd4;
      KW_WHILE:  n = 3'd5;
      KW_RETURN: n = 3'd6;
      KW_VOID:   n = 3'd4;
      default:   n = 3'd7;
    endcase
    return n;
  endfunction

  function automatic prefix_t kw_text(input logic [2:0] k);
    prefix_t t;
    t = '0;
    case (k)
      KW_INT: begin
        t[0] = "i"; t[1] = "n"; t[2] = "t";
      end
      KW_FLOAT: begin
        t[0] = "f"; t[1] = "l"; t[2] = "o"; t[3] = "a"; t[4] = "t";
      end
      KW_IF: begin
        t[0] = "i"; t[1] = "f";
      end
      KW_ELSE: begin
        t[0] = "e"; t[1] = "l"; t[2] = "s"; t[3] = "e";
      end
      KW_WHILE: begin
        t[0] = "w"; t[1] = "h"; t[2] = "i"; t[3] = "l"; t[4] = "e";
      end
      KW_RETURN: begin
        t[0] = "r"; t[1] = "e"; t[2] = "t"; t[3] = "u"; t[4] = "r"; t[5] = "n";
      end
      KW_VOID: begin
        t[0] = "v"; t[1] = "o"; t[2] = "i"; t[3] = "d";
      end
      default: t = '0;
    endcase
    return t;
  endfunction

  // Compare the stored prefix against all keywords in parallel.
  function automatic logic [2:0] keyword_of(input prefix_t prefix, input logic [2:0] len);
    logic [2:0] res;
    logic       hit;
    prefix_t    t;
    res = KW_NONE;
    for (int k = 6; k >= 0; k--) begin
      t   = kw_text(3'(k));
      hit = (kw_len(3'(k)) == len);
      for (int j = 0; j < PREFIX_LEN; j++) begin
        if ((3'(j) < len) && (t[j] != prefix[j])) hit = 1'b0;
      end
      if (hit) res = 3'(k);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ sv/csl_scan.sv @@
// ----------------------------------------------------------------------------
// csl_scan
// Scanner state and token generation, one source byte per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module csl_scan #(
  parameter int unsigned MAX_TOKEN_LEN = csl_pkg::MAX_TOKEN_LEN_DEF,
  parameter int unsigned OFFSET_BITS   = csl_pkg::OFFSET_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire csl_pkg::csl_in_t   in_i,
  output csl_pkg::csl_push_t      push_o
);

  localparam int unsigned LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_SLASH  = 3'd3;
  localparam logic [2:0] MODE_LINE   = 3'd4;
  localparam logic [2:0] MODE_BLOCK  = 3'd5;
  localparam logic [2:0] MODE_STAR   = 3'd6;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  logic [2:0]             mode_q, mode_d;
  logic [LEN_W-1:0]       run_len_q;
  logic [OFFSET_BITS-1:0] run_start_q;
  logic                   ovf_q;
  logic [15:0]            line_q;
  logic [OFFSET_BITS-1:0] offset_q;
  csl_pkg::prefix_t       prefix_q;

  logic [7:0] c;
  logic       is_end, is_ws, is_nl, is_alpha, is_digit, is_sep;
  logic       flush_v, byte_v, go_idle, line_inc, begin_run, extend;
  logic       is_short;
  logic [2:0] kw;
  logic [OFFSET_BITS+15:0] start_ext, offset_ext;
  logic [LEN_W+7:0]        len_ext;
  csl_pkg::csl_out_t       flush_tok, byte_tok;

  assign c        = in_i.ch;
  assign is_end   = in_i.end_of_text || (c == 8'd0);
  assign is_nl    = (c == "\n");
  assign is_ws    = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  assign is_digit = (c >= "0") && (c <= "9");
  assign is_sep   = (c == "{") || (c == "}") || (c == ";") || (c == "(") || (c == ")");

  // Next mode and side effects for this byte
  always_comb begin
    mode_d    = mode_q;
    flush_v   = 1'b0;
    byte_v    = 1'b0;
    go_idle   = 1'b0;
    line_inc  = 1'b0;
    begin_run = 1'b0;
    extend    = 1'b0;
    if (is_end) begin
      flush_v = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER) || (mode_q == MODE_SLASH);
      mode_d  = MODE_IDLE;
    end else begin
      unique case (mode_q)
        MODE_IDENT: begin
          if (is_alpha || is_digit) extend = 1'b1;
          else begin
            flush_v = 1'b1;
            go_idle = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit) extend = 1'b1;
          else begin
            flush_v = 1'b1;
            go_idle = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (c == "/") mode_d = MODE_LINE;
          else if (c == "*") mode_d = MODE_BLOCK;
          else begin
            flush_v = 1'b1;
            go_idle = 1'b1;
          end
        end
        MODE_LINE: begin
          if (is_nl) begin
            line_inc = 1'b1;
            mode_d   = MODE_IDLE;
          end
        end
        MODE_BLOCK: begin
          if (c == "*") mode_d = MODE_STAR;
          else if (is_nl) line_inc = 1'b1;
        end
        MODE_STAR: begin
          if (c == "/") mode_d = MODE_IDLE;
          else if (c != "*") begin
            line_inc = is_nl;
            mode_d   = MODE_BLOCK;
          end
        end
        default: go_idle = 1'b1;
      endcase
      if (go_idle) begin
        mode_d = MODE_IDLE;
        if (is_ws) line_inc = is_nl;
        else if (is_alpha) begin
          begin_run = 1'b1;
          mode_d    = MODE_IDENT;
        end else if (is_digit) begin
          begin_run = 1'b1;
          mode_d    = MODE_NUMBER;
        end else if (c == "/") begin
          begin_run = 1'b1;
          mode_d    = MODE_SLASH;
        end else begin
          byte_v = 1'b1;
        end
      end
    end
  end

  // Token that closes the open run
  assign is_short   = !ovf_q && (run_len_q <= LEN_W'(csl_pkg::PREFIX_LEN));
  assign kw         = is_short ? csl_pkg::keyword_of(prefix_q, run_len_q[2:0])
                               : csl_pkg::KW_NONE;
  assign start_ext  = (OFFSET_BITS + 16)'(run_start_q);
  assign offset_ext = (OFFSET_BITS + 16)'(offset_q);
  assign len_ext    = (LEN_W + 8)'(run_len_q);

  always_comb begin
    flush_tok.keyword_index = csl_pkg::KW_NONE;
    flush_tok.first_char    = prefix_q[0];
    flush_tok.token_start   = start_ext[15:0];
    flush_tok.token_length  = len_ext[7:0];
    flush_tok.token_line    = line_q;
    flush_tok.too_long      = ovf_q;
    flush_tok.last          = 1'b1;
    case (mode_q)
      MODE_IDENT: begin
        flush_tok.keyword_index = kw;
        flush_tok.token_kind    = (kw == csl_pkg::KW_NONE) ? csl_pkg::KIND_IDENT
                                                          : csl_pkg::KIND_KEYWORD;
      end
      MODE_NUMBER: flush_tok.token_kind = csl_pkg::KIND_LITERAL;
      default: begin
        flush_tok.token_kind = csl_pkg::KIND_UNKNOWN;
        flush_tok.first_char = "/";
      end
    endcase
  end

  // One-byte token started by this byte
  always_comb begin
    byte_tok.token_kind    = is_sep ? csl_pkg::KIND_SEP : csl_pkg::KIND_UNKNOWN;
    byte_tok.keyword_index = csl_pkg::KW_NONE;
    byte_tok.first_char    = c;
    byte_tok.token_start   = offset_ext[15:0];
    byte_tok.token_length  = 8'd1;
    byte_tok.token_line    = line_q;
    byte_tok.too_long      = 1'b0;
    byte_tok.last          = 1'b1;
  end

  always_comb begin
    push_o.tok1 = byte_tok;
    push_o.tok0 = flush_v ? flush_tok : byte_tok;
    if (flush_v && byte_v) push_o.tok0.last = 1'b0;
    push_o.push_n = fire_i ? (2'(flush_v) + 2'(byte_v)) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      run_len_q   <= '0;
      run_start_q <= '0;
      ovf_q       <= 1'b0;
      line_q      <= 16'd1;
      offset_q    <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      if (line_inc && (line_q != LINE_MAX)) line_q <= line_q + 16'd1;
      if (!is_end) offset_q <= offset_q + OFFSET_BITS'(1);
      if (begin_run) begin
        run_len_q   <= LEN_W'(1);
        run_start_q <= offset_q;
        ovf_q       <= 1'b0;
      end else if (extend) begin
        if (run_len_q < LEN_W'(MAX_TOKEN_LEN)) run_len_q <= run_len_q + LEN_W'(1);
        else ovf_q <= 1'b1;
      end
    end
  end

  // Prefix bytes feed the keyword compare and the flushed token's first char
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      if (begin_run) prefix_q[0] <= c;
      else if (extend && (run_len_q < LEN_W'(csl_pkg::PREFIX_LEN))) begin
        prefix_q[run_len_q[csl_pkg::PREFIX_IDX_W-1:0]] <= c;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/csl_queue.sv @@
// ----------------------------------------------------------------------------
// csl_queue
// Token queue: takes up to two tokens per cycle, delivers one.
// ----------------------------------------------------------------------------
`default_nettype none

module csl_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire csl_pkg::csl_push_t     push_i,
  input  wire logic                   pop_i,
  output csl_pkg::csl_out_t           data_o,
  output logic                        valid_o,
  output csl_pkg::csl_queue_stat_t    stat_o
);

  localparam int unsigned PW = csl_pkg::QUEUE_PTR_W;

  csl_pkg::csl_out_t mem_q [csl_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PW:0]       level_q;

  assign valid_o         = (level_q != '0);
  assign data_o          = mem_q[rd_ptr_q];
  assign stat_o.level    = level_q;
  assign stat_o.room_two = (level_q <= (PW + 1)'(csl_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.push_n != 2'd0) mem_q[wr_ptr_q] <= push_i.tok0;
    if (push_i.push_n == 2'd2) mem_q[wr_ptr_q + PW'(1)] <= push_i.tok1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PW'(push_i.push_n);
      rd_ptr_q <= rd_ptr_q + PW'(pop_i);
      level_q  <= level_q + (PW + 1)'(push_i.push_n) - (PW + 1)'(pop_i);
    end
  end

endmodule

`default_nettype wire

@@ sv/c_subset_lexer_unit.sv @@
// ----------------------------------------------------------------------------
// c_subset_lexer_unit
// Streaming tokenizer for a small C subset: source bytes in, tokens out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------
//  in      | input     | in_valid_i/in_stall_o | csl_in_t  (ch, end_of_text)
//  out     | output    | out_valid_o/out_stall_i | csl_out_t (one token)
//
//  One source byte is taken per cycle unless stalled; its scan state update
//  and token build finish in the cycle it is accepted, and the tokens land in
//  a 4-entry queue. A byte yields zero, one or two tokens; the single output
//  port delivers one token per cycle unless stalled, so sustained rate is one
//  byte per cycle while tokens average at most one per byte. in_stall_o rises
//  when the queue has room for fewer than two tokens. Reset clears scan mode,
//  run counters, offset (0), line (1) and queue; keyword prefix is not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module c_subset_lexer_unit #(
  parameter int unsigned MAX_TOKEN_LEN = csl_pkg::MAX_TOKEN_LEN_DEF,
  parameter int unsigned OFFSET_BITS   = csl_pkg::OFFSET_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire csl_pkg::csl_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output csl_pkg::csl_out_t      out_data_o
);

  logic                      in_fire;
  logic                      out_fire;
  csl_pkg::csl_push_t        push;
  csl_pkg::csl_queue_stat_t  q_stat;

  // Hold off new bytes unless both tokens of a worst-case byte fit.
  assign in_stall_o = !q_stat.room_two;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_o && !out_stall_i;

  csl_scan #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .in_i   (in_data_i),
    .push_o (push)
  );

  // Advance the read side on every delivered token.
  csl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_fire),
    .data_o  (out_data_o),
    .valid_o (out_valid_o),
    .stat_o  (q_stat)
  );

  `ASSERT_DEF(a_level_bound, q_stat.level <= (csl_pkg::QUEUE_PTR_W + 1)'(csl_pkg::QUEUE_DEPTH), "token queue overfilled")
  `ASSERT_DEF(a_pair_order, (push.push_n == 2'd2) |-> (!push.tok0.last && push.tok1.last), "last flag misplaced on token pair")
  `ASSERT_DEF(a_single_last, (push.push_n == 2'd1) |-> push.tok0.last, "single token not marked last")

endmodule

`default_nettype wire
